>>> rtl/core/hlxfp_pkg.sv
// Shared types and constants for the header, length and XOR frame parser.
`default_nettype none
package hlxfp_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h55;
   localparam logic [7:0] HDR_SECOND = 8'hAA;
   localparam logic [7:0] MIN_LENGTH = 8'd2;
   localparam logic [7:0] MAX_LENGTH_RESET = 8'd29;

   typedef enum logic [2:0] {
      PH_HUNT0 = 3'd0,
      PH_HUNT1 = 3'd1,
      PH_LEN   = 3'd2,
      PH_ID    = 3'd3,
      PH_DATA  = 3'd4,
      PH_CHECK = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_GOOD      = 2'd0,
      ST_CHECKSUM  = 2'd1,
      ST_LENGTH    = 2'd2,
      ST_RESERVED  = 2'd3
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  msg_id;
      logic [7:0]  payload_count;
      logic [7:0]  first_payload;
      logic [7:0]  second_payload;
   } result_type;

   // Register index of max_length in the CSR space.
   localparam logic REG_MAX_LENGTH = 1'b0;

endpackage : hlxfp_pkg
`default_nettype wire

>>> rtl/core/hlxfp_csr.sv
// APB-style configuration register holding max_length.
`default_nettype none
module hlxfp_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output logic [7:0]       max_length
);
   import hlxfp_pkg::*;

   logic [7:0] max_length_ff;
   logic [7:0] max_length_in;
   logic       hit;

   assign csr_pready = 1'b1;
   assign hit = (csr_paddr[2] == REG_MAX_LENGTH) && (csr_paddr[1:0] == 2'b00);

   always_comb begin
      max_length_in = max_length_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit) begin
         max_length_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         max_length_ff <= max_length_in;
      end
   end

   assign csr_prdata = hit ? {24'd0, max_length_ff} : 32'd0;
   assign max_length = max_length_ff;

endmodule : hlxfp_csr
`default_nettype wire

>>> rtl/core/hlxfp_parse.sv
// Frame parser state machine: header hunt, length check, XOR and result build.
`default_nettype none
module hlxfp_parse (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [7:0]           in_byte,
   input  wire logic [7:0]           max_length,
   output logic                      res_valid,
   output hlxfp_pkg::result_type     res
);
   import hlxfp_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] id_ff, id_in;
   logic [7:0] seen_ff, seen_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] pay1_ff, pay1_in;
   logic [7:0] pay2_ff, pay2_in;
   logic       length_bad;
   logic [7:0] seen_next;

   assign length_bad = (in_byte < MIN_LENGTH) || (in_byte > max_length);
   assign seen_next  = seen_ff + 8'd1;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (in_valid) begin
         case (phase_ff)
            PH_HUNT1: phase_in = (in_byte == HDR_SECOND) ? PH_LEN : PH_HUNT0;
            PH_LEN:   phase_in = length_bad ? PH_HUNT0 : PH_ID;
            PH_ID:    phase_in = PH_DATA;
            PH_DATA:  phase_in = ((seen_next + 8'd1) >= length_ff) ? PH_CHECK : PH_DATA;
            PH_CHECK: phase_in = PH_HUNT0;
            default:  phase_in = (in_byte == HDR_FIRST) ? PH_HUNT1 : PH_HUNT0;
         endcase
      end
   end

   // Datapath updates and result
   always_comb begin
      length_in = length_ff;
      id_in     = id_ff;
      seen_in   = seen_ff;
      xor_in    = xor_ff;
      pay1_in   = pay1_ff;
      pay2_in   = pay2_ff;
      res_valid = 1'b0;
      res       = '0;
      res.status = ST_GOOD;
      if (in_valid) begin
         case (phase_ff)
            PH_LEN: begin
               if (length_bad) begin
                  res_valid  = 1'b1;
                  res.status = ST_LENGTH;
               end else begin
                  length_in = in_byte;
                  xor_in    = in_byte;
               end
            end
            PH_ID: begin
               id_in   = in_byte;
               xor_in  = xor_ff ^ in_byte;
               seen_in = 8'd0;
               pay1_in = 8'd0;
               pay2_in = 8'd0;
            end
            PH_DATA: begin
               if (seen_ff == 8'd0) begin
                  pay1_in = in_byte;
               end else if (seen_ff == 8'd1) begin
                  pay2_in = in_byte;
               end
               xor_in  = xor_ff ^ in_byte;
               seen_in = seen_next;
            end
            PH_CHECK: begin
               res_valid          = 1'b1;
               res.status         = (in_byte == xor_ff) ? ST_GOOD : ST_CHECKSUM;
               res.msg_id         = id_ff;
               res.payload_count  = length_ff - 8'd1;
               res.first_payload  = pay1_ff;
               res.second_payload = pay2_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT0;
         length_ff <= 8'd0;
         id_ff     <= 8'd0;
         seen_ff   <= 8'd0;
         xor_ff    <= 8'd0;
         pay1_ff   <= 8'd0;
         pay2_ff   <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         id_ff     <= id_in;
         seen_ff   <= seen_in;
         xor_ff    <= xor_in;
         pay1_ff   <= pay1_in;
         pay2_ff   <= pay2_in;
      end
   end

   a_check_gives_result: assert property (@(posedge clock) disable iff (reset)
      (in_valid && phase_ff == PH_CHECK) |-> res_valid)
      else $error("check byte did not produce a result");

   a_result_rehunts: assert property (@(posedge clock) disable iff (reset)
      (in_valid && res_valid) |=> (phase_ff == PH_HUNT0))
      else $error("parser did not return to hunting after a result");

   a_data_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (({1'b0, seen_ff} + 9'd2) <= {1'b0, length_ff}))
      else $error("payload count ran past the length byte");

endmodule : hlxfp_parse
`default_nettype wire

>>> rtl/core/hlxfp_out.sv
// Result register in front of the rsp channel.
`default_nettype none
module hlxfp_out (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire hlxfp_pkg::result_type load_data,
   output logic                       can_take,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [31:0]                rsp_tdata,
   output logic [1:0]                 rsp_tuser
);
   import hlxfp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // Free when empty or when the held item leaves this cycle.
   assign can_take = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {data_ff.second_payload, data_ff.first_payload,
                        data_ff.payload_count, data_ff.msg_id};
   assign rsp_tuser  = data_ff.status;

endmodule : hlxfp_out
`default_nettype wire

>>> rtl/core/header_length_xor_frame_parser.sv
// Top level: header/length/XOR frame parser with stream channels and APB CSR.
//
// The req channel carries one received byte per item. The block hunts for the
// header 0x55 0xAA, reads a length byte, an id byte and length-1 payload bytes,
// and compares the next byte with the XOR of length, id and payload. It then
// emits one rsp item with the status, id, payload count and first two payload
// bytes. A length byte below 2 or above max_length emits a length-error item
// at once and hunting resumes.
// Output: a result is registered and shows on rsp in the cycle after its byte.
// Throughput: one byte per cycle while the result register can take; the state
// update and result build sit between the parser state and result registers.
// Stall: req_tready stays high while the result register is empty or its item
// is taken in the same cycle; a stalled result holds and blocks new bytes.
// Reset: synchronous; the parser hunts for 0x55, the result register empties
// and max_length returns to 29. The CSR port takes writes at any time; change
// max_length only while no frame is in progress.
`default_nettype none
module header_length_xor_frame_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [7:0] msg_id, [15:8] payload_count,
                                         // [23:16] first_payload, [31:24] second_payload
   output logic [1:0]       rsp_tuser,   // [1:0] status
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import hlxfp_pkg::*;

   logic       accept;
   logic       res_valid;
   logic       can_take;
   logic [7:0] max_length;
   result_type res;

   assign req_tready = can_take;
   assign accept     = req_tvalid && req_tready;

   hlxfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_length  (max_length)
   );

   hlxfp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_byte    (req_tdata),
      .max_length (max_length),
      .res_valid  (res_valid),
      .res        (res)
   );

   hlxfp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (res_valid),
      .load_data  (res),
      .can_take   (can_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("byte taken while result register was stalled");

   a_result_follows_load: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> rsp_tvalid)
      else $error("result was lost");

   a_length_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_LENGTH) |-> (rsp_tdata == 32'd0))
      else $error("length error item carries nonzero fields");

endmodule : header_length_xor_frame_parser
`default_nettype wire
